/* src/tcw_pkg.sv */
package tcw_pkg;

    localparam int MAX_ROWS    = 128;
    localparam int MAX_COLS    = 256;
    localparam int ROWS_DEF    = 25;
    localparam int COLS_DEF    = 80;
    localparam int CMD_ADDR_W  = $clog2(MAX_ROWS * MAX_COLS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic       REQ_PUT    = 1'b0;
    localparam logic       REQ_READ   = 1'b1;
    localparam logic [7:0] CODE_BS    = 8'd8;
    localparam logic [7:0] CODE_NL    = 8'd10;
    localparam logic [7:0] CODE_SPACE = 8'h20;
    localparam logic [3:0] FG_RESET   = 4'd7;
    localparam logic [15:0] BLANK_CELL = 16'h0720;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_req;

    typedef struct packed {
        logic [15:0] cell_entry;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
    } t_rsp;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_READ
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic                  scroll;
        logic [CMD_ADDR_W-1:0] addr;
        logic [7:0]            char_code;
        logic [4:0]            cursor_row;
        logic [6:0]            cursor_col;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_WAIT,
        ST_SCROLL,
        ST_BLANK
    } t_back_state;

endpackage

/* src/tcw_ram.sv */
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tcw_queue.sv */
module tcw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output tcw_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import tcw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd   = r_slot[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

endmodule

/* src/tcw_front.sv */
module tcw_front #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tcw_pkg::t_req i_req,
    input  logic          i_full,
    input  logic          i_clearing,
    output logic          o_busy,
    output logic          o_push,
    output tcw_pkg::t_cmd o_cmd
);
    import tcw_pkg::*;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ADDR_W = $clog2(ROWS * COLS);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLS - 1);
    localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((ROWS - 1) * COLS);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);

    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [ADDR_W-1:0] r_addr;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  n_col;
    logic [ADDR_W-1:0] n_addr;
    logic [15:0]       rd_lin;
    logic              rd_ok;
    t_cmd              cmd;

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_addr = r_addr;
        cmd    = '0;
        cmd.kind      = CMD_NONE;
        cmd.scroll    = 1'b0;
        cmd.char_code = i_req.char_code;
        cmd.addr      = CMD_ADDR_W'(r_addr);
        rd_lin = 16'(i_req.read_row) * 16'(COLS) + 16'(i_req.read_col);
        rd_ok  = (16'(i_req.read_row) < 16'(ROWS)) && (16'(i_req.read_col) < 16'(COLS));

        if (i_req.req_type == REQ_READ) begin
            if (rd_ok) begin
                cmd.kind = CMD_READ;
                cmd.addr = CMD_ADDR_W'(ADDR_W'(rd_lin));
            end
        end else if (i_req.char_code == CODE_BS) begin
            if (r_col != '0) begin
                n_col  = r_col - COL_W'(1);
                n_addr = r_addr - ADDR_W'(1);
            end else if (r_row != '0) begin
                n_row  = r_row - ROW_W'(1);
                n_col  = LAST_COL;
                n_addr = r_addr - ADDR_W'(1);
            end
            cmd.kind      = CMD_WRITE;
            cmd.char_code = CODE_SPACE;
            cmd.addr      = CMD_ADDR_W'(n_addr);
        end else if (i_req.char_code == CODE_NL) begin
            n_col = '0;
            if (r_row == LAST_ROW) begin
                cmd.scroll = 1'b1;
                n_addr     = LAST_BASE;
            end else begin
                n_row  = r_row + ROW_W'(1);
                n_addr = r_addr - ADDR_W'(r_col) + COLS_A;
            end
        end else begin
            cmd.kind = CMD_WRITE;
            if (r_col == LAST_COL) begin
                n_col = '0;
                if (r_row == LAST_ROW) begin
                    cmd.scroll = 1'b1;
                    n_addr     = LAST_BASE;
                end else begin
                    n_row  = r_row + ROW_W'(1);
                    n_addr = r_addr + ADDR_W'(1);
                end
            end else begin
                n_col  = r_col + COL_W'(1);
                n_addr = r_addr + ADDR_W'(1);
            end
        end

        cmd.cursor_row = 5'(n_row);
        cmd.cursor_col = 7'(n_col);
    end

    assign o_busy = i_full | i_clearing;
    assign o_push = i_start & ~o_busy;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_addr <= '0;
        end else if (o_push) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_addr <= n_addr;
        end
    end

endmodule

/* src/tcw_back.sv */
module tcw_back #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_wdata,
    input  logic          i_empty,
    input  tcw_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_clearing,
    output logic          o_done,
    output tcw_pkg::t_rsp o_rsp
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((ROWS - 1) * COLS);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);

    t_back_state       r_state;
    t_back_state       n_state;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] n_idx;
    t_cmd              r_pend;
    t_cmd              n_pend;
    logic              r_done;
    logic              n_done;
    t_rsp              r_rsp;
    t_rsp              n_rsp;
    logic [3:0]        r_fg;
    logic [15:0]       blank;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    tcw_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        blank     = {4'b0000, r_fg, CODE_SPACE};
        n_state   = r_state;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = blank;
        ram_raddr = r_idx + COLS_A;
        o_pop     = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = BLANK_CELL;
                if (r_idx == LAST_CELL) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_pend = i_cmd;
                    unique case (i_cmd.kind)
                        CMD_WRITE: begin
                            ram_we    = 1'b1;
                            ram_waddr = ADDR_W'(i_cmd.addr);
                            ram_wdata = {4'b0000, r_fg, i_cmd.char_code};
                        end
                        CMD_READ: begin
                            ram_raddr = ADDR_W'(i_cmd.addr);
                        end
                        default: begin
                        end
                    endcase
                    if (i_cmd.kind == CMD_READ) begin
                        n_state = ST_READ_WAIT;
                    end else if (i_cmd.scroll) begin
                        n_idx   = '0;
                        n_state = ST_SCROLL;
                    end else begin
                        n_done           = 1'b1;
                        n_rsp.cell_entry = '0;
                        n_rsp.cursor_row = i_cmd.cursor_row;
                        n_rsp.cursor_col = i_cmd.cursor_col;
                    end
                end
            end
            ST_READ_WAIT: begin
                n_done           = 1'b1;
                n_rsp.cell_entry = ram_rdata;
                n_rsp.cursor_row = r_pend.cursor_row;
                n_rsp.cursor_col = r_pend.cursor_col;
                n_state          = ST_IDLE;
            end
            ST_SCROLL: begin
                if (r_idx != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx - ADDR_W'(1);
                    ram_wdata = ram_rdata;
                end
                if (r_idx == LAST_BASE) begin
                    n_state = ST_BLANK;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            ST_BLANK: begin
                ram_we = 1'b1;
                if (r_idx == LAST_CELL) begin
                    n_idx            = '0;
                    n_done           = 1'b1;
                    n_rsp.cell_entry = '0;
                    n_rsp.cursor_row = r_pend.cursor_row;
                    n_rsp.cursor_col = r_pend.cursor_col;
                    n_state          = ST_IDLE;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
            r_done  <= 1'b0;
            r_fg    <= FG_RESET;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_fg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_rsp  <= n_rsp;
    end

    assign o_clearing = (r_state == ST_CLEAR);
    assign o_done     = r_done;
    assign o_rsp      = r_rsp;

endmodule

/* src/text_terminal_cursor_writer_top.sv */
// Channel   Direction  Handshake                     Payload
// request   in         start high while busy low     i_req  (tcw_pkg::t_req)
// result    out        o_done high for one cycle     o_rsp  (tcw_pkg::t_rsp)
// colour    in         i_cfg_we                      i_cfg_wdata
//
// A put, newline or off-screen read beat gives its result once the back end has popped it from the
// queue; an on-screen read also passes through ST_READ_WAIT for the registered screen memory. A
// beat that scrolls copies each row up and blanks the last one cell by cell through the single
// write port of the screen memory. After reset a clearing pass over all ROWS*COLS cells holds busy
// high. Busy is also high while the two-entry command queue is full; results cannot be held off.
module text_terminal_cursor_writer_top #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  tcw_pkg::t_req i_req,
    output logic          o_done,
    output tcw_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_wdata
);
    import tcw_pkg::*;

    logic full;
    logic empty;
    logic push;
    logic pop;
    logic clearing;
    t_cmd cmd_in;
    t_cmd cmd_out;

    tcw_front #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (i_req),
        .i_full    (full),
        .i_clearing(clearing),
        .o_busy    (busy),
        .o_push    (push),
        .o_cmd     (cmd_in)
    );

    tcw_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (cmd_in),
        .i_pop  (pop),
        .o_cmd  (cmd_out),
        .o_full (full),
        .o_empty(empty)
    );

    tcw_back #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_empty    (empty),
        .i_cmd      (cmd_out),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_done     (o_done),
        .o_rsp      (o_rsp)
    );

endmodule
